[hw/rtl/pkvm_pkg.sv]
// Shared types, constants and register codes of the keyed value masker.
package pkvm_pkg;

  localparam int unsigned WordW        = 64;
  localparam int unsigned HalfW        = 32;
  localparam int unsigned CfgIndexW    = 2;
  localparam int unsigned DefQueueDepth = 2;

  // LCG multiplier of the noise generator, split into halves
  localparam logic [WordW-1:0] PcgMult   = 64'd6364136223846793005;
  localparam logic [HalfW-1:0] PcgMultLo = PcgMult[HalfW-1:0];
  localparam logic [HalfW-1:0] PcgMultHi = PcgMult[WordW-1:HalfW];

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_XOR_KEY          = 2'd0,
    REG_MULT_KEY         = 2'd1,
    REG_MULT_KEY_INVERSE = 2'd2,
    REG_STREAM_INCREMENT = 2'd3
  } reg_index_t;

  // Command codes
  typedef enum logic {
    CMD_MASK   = 1'b0,
    CMD_UNMASK = 1'b1
  } command_t;

  typedef struct packed {
    logic [WordW-1:0] xor_key;
    logic [WordW-1:0] mult_key;
    logic [WordW-1:0] mult_key_inverse;
    logic [WordW-1:0] stream_increment;
  } keys_t;

  // Work item handed from the front to the back: multiply operand by factor
  typedef struct packed {
    command_t         command;
    logic [WordW-1:0] operand;
    logic [WordW-1:0] factor;
  } work_t;

endpackage

[hw/rtl/pkvm_ifs.sv]
// Valid/ready channel interfaces for commands and results.
interface pkvm_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] operand_word;

  modport source (output valid, output command, output operand_word, input ready);
  modport sink   (input valid, input command, input operand_word, output ready);
endinterface

interface pkvm_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word;

  modport source (output valid, output result_word, input ready);
  modport sink   (input valid, input result_word, output ready);
endinterface

[hw/rtl/pkvm_front.sv]
// Front end: accepts commands, draws noise, advances the generator, builds work items.
module pkvm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  pkvm_pkg::keys_t       keys,
  pkvm_cmd_if.sink              request,
  input  logic                  queue_full,
  output logic                  push,
  output pkvm_pkg::work_t       work
);
  import pkvm_pkg::*;

  logic [WordW-1:0] gen_state;
  logic [WordW-1:0] gen_state_next;
  logic [WordW-1:0] pp_ll;
  logic [HalfW-1:0] pp_lh;
  logic [HalfW-1:0] pp_hl;
  logic [WordW-1:0] incr;
  logic [WordW-1:0] mixed_wide;
  logic [HalfW-1:0] mixed;
  logic [4:0]       turn;
  logic [2*HalfW-1:0] rot_pair;
  logic [HalfW-1:0] noise;
  logic [HalfW-1:0] hidden;
  logic [WordW-1:0] joined;
  logic             is_mask;

  // Accept whenever the queue has room
  assign request.ready = !queue_full;
  assign push          = request.valid && !queue_full;
  assign is_mask       = (command_t'(request.command) == CMD_MASK);

  // XSH-RR output of the current state
  assign mixed_wide = (gen_state >> 18) ^ gen_state;
  assign mixed      = mixed_wide[58:27];
  assign turn       = gen_state[63:59];
  assign rot_pair   = {mixed, mixed} >> turn;
  assign noise      = rot_pair[HalfW-1:0];

  // LCG step from three 32x32 partial products
  assign pp_ll = {32'd0, gen_state[HalfW-1:0]} * {32'd0, PcgMultLo};
  assign pp_lh = gen_state[WordW-1:HalfW] * PcgMultLo;
  assign pp_hl = gen_state[HalfW-1:0] * PcgMultHi;
  assign incr  = keys.stream_increment | 64'd1;
  assign gen_state_next = pp_ll + {pp_lh + pp_hl, 32'd0} + incr;

  // Form the word that the back end multiplies
  assign hidden = request.operand_word[HalfW-1:0] ^ noise;
  assign joined = {hidden, 32'd0} ^ {32'd0, noise};

  always_comb begin
    work.command = command_t'(request.command);
    if (is_mask) begin
      work.operand = joined ^ keys.xor_key;
      work.factor  = keys.mult_key;
    end else begin
      work.operand = request.operand_word;
      work.factor  = keys.mult_key_inverse;
    end
  end

  // Advance the generator on accepted mask transactions only
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
    end else if (push && is_mask) begin
      gen_state <= gen_state_next;
    end
  end

endmodule

[hw/rtl/pkvm_queue.sv]
// Short FIFO of work items between the front and back ends.
module pkvm_queue #(
  parameter int unsigned QUEUE_DEPTH = pkvm_pkg::DefQueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pkvm_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output pkvm_pkg::work_t pop_data
);
  import pkvm_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  work_t           slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/pkvm_back.sv]
// Back end: pipelined 64-bit modular multiply, unmask fold, output register.
module pkvm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [63:0]           xor_key,
  input  logic                  work_valid,
  input  pkvm_pkg::work_t       work,
  output logic                  work_pop,
  pkvm_res_if.source            response
);
  import pkvm_pkg::*;

  // Partial product stage
  logic             pp_valid;
  command_t         pp_command;
  logic [WordW-1:0] pp_ll;
  logic [HalfW-1:0] pp_lh;
  logic [HalfW-1:0] pp_hl;

  // Output stage
  logic             out_valid;
  logic [WordW-1:0] out_word;

  logic             out_load;
  logic             pp_load;
  logic [WordW-1:0] product;
  logic [WordW-1:0] unmasked;
  logic [WordW-1:0] finished;

  // Stage enables: move when the next stage is free or draining
  assign out_load = !out_valid || response.ready;
  assign pp_load  = !pp_valid || out_load;
  assign work_pop = work_valid && pp_load;

  // Sum partial products modulo 2^64 and finish per command
  assign product  = pp_ll + {pp_lh + pp_hl, 32'd0};
  assign unmasked = product ^ xor_key;

  always_comb begin
    unique case (pp_command)
      CMD_MASK:   finished = product;
      CMD_UNMASK: finished = {32'd0, unmasked[WordW-1:HalfW] ^ unmasked[HalfW-1:0]};
      default:    finished = product;
    endcase
  end

  // Partial product registers
  always_ff @(posedge clk) begin
    if (pp_load) begin
      pp_command <= work.command;
      pp_ll      <= {32'd0, work.operand[HalfW-1:0]} * {32'd0, work.factor[HalfW-1:0]};
      pp_lh      <= work.operand[WordW-1:HalfW] * work.factor[HalfW-1:0];
      pp_hl      <= work.operand[HalfW-1:0] * work.factor[WordW-1:HalfW];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load && pp_valid) begin
      out_word <= finished;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pp_load) begin
        pp_valid <= work_valid;
      end
      if (out_load) begin
        out_valid <= pp_valid;
      end
    end
  end

  assign response.valid       = out_valid;
  assign response.result_word = out_word;

endmodule

[hw/rtl/pcg_keyed_value_masker_core.sv]
// Top level of the keyed value masker: key registers, front, queue and back end.
//
//  channel    dir  signals                                 transaction
//  request    in   valid ready command operand_word        one mask or unmask command
//  response   out  valid ready result_word                 one 64-bit result
//  cfg        in   cfg_we cfg_index cfg_data               one key register write
//
// One command per cycle sustained while response.ready holds; a result passes the queue,
// the partial product registers and the output register after its command is accepted.
// The generator update is a combinational loop through its state register and allows that rate.
// rst is synchronous: keys return to 0/1/1/0, the generator state to zero.
// A stalled response fills the pipeline, then the queue, then drops request.ready.
module pcg_keyed_value_masker_core #(
  parameter int unsigned QUEUE_DEPTH = pkvm_pkg::DefQueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pkvm_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pkvm_pkg::WordW-1:0]     cfg_data,
  pkvm_cmd_if.sink                      request,
  pkvm_res_if.source                    response
);
  import pkvm_pkg::*;

  keys_t keys;
  logic  push;
  work_t push_work;
  logic  queue_full;
  logic  queue_not_empty;
  logic  pop;
  work_t pop_work;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keys.xor_key          <= '0;
      keys.mult_key         <= 64'd1;
      keys.mult_key_inverse <= 64'd1;
      keys.stream_increment <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_XOR_KEY:          keys.xor_key          <= cfg_data;
        REG_MULT_KEY:         keys.mult_key         <= cfg_data;
        REG_MULT_KEY_INVERSE: keys.mult_key_inverse <= cfg_data;
        REG_STREAM_INCREMENT: keys.stream_increment <= cfg_data;
        default: ;
      endcase
    end
  end

  pkvm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .keys       (keys),
    .request    (request),
    .queue_full (queue_full),
    .push       (push),
    .work       (push_work)
  );

  pkvm_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_work),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .pop_data  (pop_work)
  );

  pkvm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .xor_key    (keys.xor_key),
    .work_valid (queue_not_empty),
    .work       (pop_work),
    .work_pop   (pop),
    .response   (response)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench of the keyed value masker core.
`timescale 1ns / 100ps

module tb;
  import pkvm_pkg::*;

  // Predicts masked and unmasked words and checks the results in order
  class masker_scoreboard;
    bit [WordW-1:0] xor_key;
    bit [WordW-1:0] mult_key;
    bit [WordW-1:0] mult_inv;
    bit [WordW-1:0] stream_inc;
    bit [WordW-1:0] gen_state;
    bit [WordW-1:0] expected_words[$];
    int             mismatches;
    int             results_seen;
    int             masks_sent;
    int             unmasks_sent;

    function new();
      xor_key      = '0;
      mult_key     = 64'd1;
      mult_inv     = 64'd1;
      stream_inc   = '0;
      gen_state    = '0;
      mismatches   = 0;
      results_seen = 0;
      masks_sent   = 0;
      unmasks_sent = 0;
    endfunction

    function void write_key(reg_index_t idx, bit [WordW-1:0] value);
      case (idx)
        REG_XOR_KEY:          xor_key    = value;
        REG_MULT_KEY:         mult_key   = value;
        REG_MULT_KEY_INVERSE: mult_inv   = value;
        REG_STREAM_INCREMENT: stream_inc = value;
        default: ;
      endcase
    endfunction

    // Advance the generator and return the rotated noise of the old state
    function bit [HalfW-1:0] draw_noise();
      bit [WordW-1:0] prev;
      bit [HalfW-1:0] mixed;
      bit [4:0]       turn;
      prev      = gen_state;
      gen_state = prev * PcgMult + (stream_inc | 64'd1);
      mixed     = 32'(((prev >> 18) ^ prev) >> 27);
      turn      = prev[63:59];
      return 32'({mixed, mixed} >> turn);
    endfunction

    // Note an accepted transaction; return the word it must produce
    function bit [WordW-1:0] note_input(command_t cmd, bit [WordW-1:0] word);
      bit [HalfW-1:0] noise;
      bit [WordW-1:0] joined;
      bit [WordW-1:0] predicted;
      if (cmd == CMD_MASK) begin
        noise     = draw_noise();
        joined    = {word[HalfW-1:0] ^ noise, noise};
        predicted = (joined ^ xor_key) * mult_key;
        masks_sent++;
      end else begin
        joined    = (word * mult_inv) ^ xor_key;
        predicted = {32'd0, joined[WordW-1:HalfW] ^ joined[HalfW-1:0]};
        unmasks_sent++;
      end
      expected_words = {expected_words, predicted};
      return predicted;
    endfunction

    function void check_result(bit [WordW-1:0] got);
      bit [WordW-1:0] want;
      results_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: got %h", results_seen, got);
      end else begin
        want = expected_words.pop_front();
        if (want != got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: expected %h, got %h",
                     results_seen, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [WordW-1:0]     cfg_data;

  pkvm_cmd_if req_if ();
  pkvm_res_if rsp_if ();

  pcg_keyed_value_masker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_if),
    .response  (rsp_if)
  );

  masker_scoreboard sb = new();
  bit               no_idle;
  int               stall_left;
  int               phases_run;
  bit [WordW-1:0]   recent_masked[$];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [WordW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Inverse of an odd multiplier modulo 2^64 by Newton iteration
  function automatic bit [WordW-1:0] odd_inverse(bit [WordW-1:0] b);
    bit [WordW-1:0] x;
    x = b;
    repeat (6) x = x * (64'd2 - b * x);
    return x;
  endfunction

  // Accept results and stall the response side at random
  always @(posedge clk) begin
    if (rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.result_word);
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 15) begin
      stall_left = pick_gap() - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Offer one transaction, hold it until accepted, then idle at random
  task automatic send_item(command_t cmd, bit [WordW-1:0] word);
    bit [WordW-1:0] predicted;
    int             gap;
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.operand_word <= word;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = sb.note_input(cmd, word);
    if (cmd == CMD_MASK) begin
      recent_masked = {recent_masked, predicted};
      if (recent_masked.size() > 16) void'(recent_masked.pop_front());
    end
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) >= 60) gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result has arrived
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four key registers while the block is idle
  task automatic load_keys(bit [WordW-1:0] x, bit [WordW-1:0] m,
                           bit [WordW-1:0] inv, bit [WordW-1:0] inc);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_XOR_KEY;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= REG_MULT_KEY;
    cfg_data  <= m;
    @(posedge clk);
    cfg_index <= REG_MULT_KEY_INVERSE;
    cfg_data  <= inv;
    @(posedge clk);
    cfg_index <= REG_STREAM_INCREMENT;
    cfg_data  <= inc;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_key(REG_XOR_KEY, x);
    sb.write_key(REG_MULT_KEY, m);
    sb.write_key(REG_MULT_KEY_INVERSE, inv);
    sb.write_key(REG_STREAM_INCREMENT, inc);
    recent_masked.delete();
  endtask

  // Mostly mask/unmask round trips, some corrupted words and raw noise
  task automatic random_phase(int count);
    int             r;
    bit [WordW-1:0] word;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 55 || recent_masked.size() == 0) begin
        send_item(CMD_MASK, rand_word());
      end else if (r < 88) begin
        send_item(CMD_UNMASK, recent_masked[$urandom_range(0, recent_masked.size() - 1)]);
      end else if (r < 94) begin
        word = recent_masked[$urandom_range(0, recent_masked.size() - 1)];
        word[$urandom_range(0, WordW - 1)] ^= 1'b1;
        send_item(CMD_UNMASK, word);
      end else begin
        send_item(CMD_UNMASK, rand_word());
      end
    end
    phases_run++;
  endtask

  initial begin
    bit [WordW-1:0] m;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_XOR_KEY;
    cfg_data            <= '0;
    req_if.valid        <= 1'b0;
    req_if.command      <= CMD_MASK;
    req_if.operand_word <= '0;
    no_idle             = 1'b0;
    phases_run          = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset keys: field extremes, upper operand bits ignored on mask
    send_item(CMD_MASK, 64'h0);
    send_item(CMD_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_MASK, 64'hFFFF_FFFF_0000_0000);
    send_item(CMD_MASK, 64'h0000_0000_FFFF_FFFF);
    send_item(CMD_UNMASK, 64'h0);
    send_item(CMD_UNMASK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_UNMASK, recent_masked[$]);

    // All-ones keys: the multiplier is its own inverse
    load_keys('1, '1, '1, '1);
    send_item(CMD_MASK, 64'h0);
    send_item(CMD_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_MASK, 64'h1234_5678_9ABC_DEF0);
    send_item(CMD_UNMASK, recent_masked[$]);
    send_item(CMD_UNMASK, 64'h0);
    send_item(CMD_UNMASK, 64'hFFFF_FFFF_FFFF_FFFF);

    // Even multiplier and an inverse that does not match it
    load_keys(64'h8000_0000_0000_0001, 64'h2, 64'h3, 64'h0);
    send_item(CMD_MASK, 64'h0000_0000_FFFF_FFFF);
    send_item(CMD_MASK, 64'hDEAD_BEEF_A5A5_A5A5);
    send_item(CMD_UNMASK, recent_masked[$]);
    send_item(CMD_UNMASK, 64'h8000_0000_0000_0000);

    // Random phases over several key settings
    m = rand_word() | 64'd1;
    load_keys(rand_word(), m, odd_inverse(m), rand_word());
    random_phase(80);

    m = rand_word() | 64'd1;
    load_keys(rand_word(), m, odd_inverse(m), rand_word());
    no_idle = 1'b1;
    random_phase(70);
    no_idle = 1'b0;

    load_keys(rand_word(), 64'd1, 64'd1, '1);
    random_phase(70);

    load_keys(rand_word(), rand_word() & ~64'd1, rand_word() | 64'd1, rand_word());
    random_phase(70);

    load_keys('1, '1, '1, 64'h0);
    random_phase(70);

    m = rand_word() | 64'd1;
    load_keys(rand_word(), m, odd_inverse(m), rand_word());
    random_phase(90);

    drain();
    $display("covered %0d masks and %0d unmasks over %0d random key phases",
             sb.masks_sent, sb.unmasks_sent, phases_run);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
